FILE: rtl/bbb_pkg.sv
// Shared types, constants and arithmetic helpers for the brightness box blur block.
package bbb_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int LINE_W     = 2 * SAMPLE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CHANS_W    = 3;
    localparam int OFFSET_W   = 9;
    localparam int ROWLEN_W   = 13;
    localparam int LAG_W      = 14;
    localparam int CHAN_CNT_W = 2;

    localparam int WIDTH_FIELD_MAX  = 2047;
    localparam int HEIGHT_FIELD_MAX = 8191;

    localparam logic [WIDTH_W-1:0]         RST_WIDTH  = 11'd512;
    localparam logic [HEIGHT_W-1:0]        RST_HEIGHT = 13'd512;
    localparam logic [CHANS_W-1:0]         RST_CHANS  = 3'd3;
    localparam logic signed [OFFSET_W-1:0] RST_OFFSET = 9'sd50;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;
    // ceil(2^16 / 9) gives an exact floor(x / 9) for x up to 9 * 255
    localparam logic [12:0] DIV9_MULT = 13'd7282;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_CHANS  = 3'd2,
        REG_OFFSET = 3'd3
    } t_reg_idx;

    typedef struct packed {
        logic [WIDTH_W-1:0]         width;
        logic [HEIGHT_W-1:0]        height;
        logic [CHANS_W-1:0]         chans;
        logic signed [OFFSET_W-1:0] offset;
        logic [ROWLEN_W-1:0]        row_len;
        logic [LAG_W-1:0]           lag;
        logic                       row_one;
    } t_geom;

    typedef struct packed {
        logic restart;
        logic busy;
    } t_cfg_ctl;

    typedef struct packed {
        logic [8:0][SAMPLE_W-1:0] tap;
        logic [SAMPLE_W-1:0]      bright;
        logic                     interior;
        logic                     last;
    } t_win;

    function automatic logic [SAMPLE_W-1:0] brighten(
        input logic [SAMPLE_W-1:0]        s,
        input logic signed [OFFSET_W-1:0] off
    );
        logic signed [9:0] v;
        v = $signed({2'b00, s}) + $signed({off[OFFSET_W-1], off});
        if (v > $signed({2'b00, SAMPLE_MAX})) begin
            return SAMPLE_MAX;
        end else if (v < 10'sd0) begin
            return '0;
        end else begin
            return v[SAMPLE_W-1:0];
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] mean9(input logic [11:0] sum);
        logic [24:0] prod;
        prod = {13'b0, sum} * {12'b0, DIV9_MULT};
        return prod[23:16];
    endfunction

endpackage

FILE: rtl/bbb_ifs.sv
// Stream and configuration channel interfaces for the brightness box blur block.
interface bbb_in_if import bbb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface bbb_out_if import bbb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] bright_value;
    logic [SAMPLE_W-1:0] filtered_value;
    logic                frame_last;

    modport source (output valid, output bright_value, output filtered_value,
                    output frame_last, input ready);
    modport sink   (input valid, input bright_value, input filtered_value,
                    input frame_last, output ready);
endinterface

interface bbb_cfg_if import bbb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/bbb_ram.sv
// Generic simple dual-port RAM with registered, read-first read port.
module bbb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bbb_cfg.sv
// Configuration registers, range saturation and derived frame geometry.
module bbb_cfg import bbb_pkg::*; #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 4096,
    parameter int MAX_CHANNELS = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bbb_cfg_if.sink  i_cfg,
    output t_geom    o_geom,
    output t_cfg_ctl o_ctl
);

    localparam int EFF_W = (MAX_WIDTH < WIDTH_FIELD_MAX) ? MAX_WIDTH : WIDTH_FIELD_MAX;
    localparam int EFF_H = (MAX_HEIGHT < HEIGHT_FIELD_MAX) ? MAX_HEIGHT : HEIGHT_FIELD_MAX;

    logic [WIDTH_W-1:0]         r_width,  n_width;
    logic [HEIGHT_W-1:0]        r_height, n_height;
    logic [CHANS_W-1:0]         r_chans,  n_chans;
    logic signed [OFFSET_W-1:0] r_offset, n_offset;
    logic                       r_settle;
    t_geom                      r_geom,   n_geom;

    logic                cfg_fire;
    logic                cfg_hit;
    logic [WIDTH_W-1:0]  w_sat;
    logic [HEIGHT_W-1:0] h_sat;
    logic [CHANS_W-1:0]  c_sat;
    logic [LAG_W-1:0]    row_prod;

    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_chans  = r_chans;
        n_offset = r_offset;
        cfg_hit  = 1'b0;
        if (cfg_fire) begin
            unique case (i_cfg.index)
                REG_WIDTH: begin
                    n_width = i_cfg.data[WIDTH_W-1:0];
                    cfg_hit = 1'b1;
                end
                REG_HEIGHT: begin
                    n_height = i_cfg.data[HEIGHT_W-1:0];
                    cfg_hit  = 1'b1;
                end
                REG_CHANS: begin
                    n_chans = i_cfg.data[CHANS_W-1:0];
                    cfg_hit = 1'b1;
                end
                REG_OFFSET: begin
                    n_offset = $signed(i_cfg.data[OFFSET_W-1:0]);
                    cfg_hit  = 1'b1;
                end
                default: cfg_hit = 1'b0;
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) begin
            w_sat = WIDTH_W'(1);
        end else if (32'(r_width) > EFF_W) begin
            w_sat = WIDTH_W'(EFF_W);
        end else begin
            w_sat = r_width;
        end

        if (r_height == '0) begin
            h_sat = HEIGHT_W'(1);
        end else if (32'(r_height) > EFF_H) begin
            h_sat = HEIGHT_W'(EFF_H);
        end else begin
            h_sat = r_height;
        end

        if (r_chans == '0) begin
            c_sat = CHANS_W'(1);
        end else if (32'(r_chans) > MAX_CHANNELS) begin
            c_sat = CHANS_W'(MAX_CHANNELS);
        end else begin
            c_sat = r_chans;
        end

        row_prod         = {3'b000, w_sat} * {11'b0, c_sat};
        n_geom.width     = w_sat;
        n_geom.height    = h_sat;
        n_geom.chans     = c_sat;
        n_geom.offset    = r_offset;
        n_geom.row_len   = row_prod[ROWLEN_W-1:0];
        n_geom.lag       = {1'b0, row_prod[ROWLEN_W-1:0]} + LAG_W'(c_sat);
        n_geom.row_one   = (row_prod == LAG_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_chans  <= RST_CHANS;
            r_offset <= RST_OFFSET;
            r_settle <= 1'b1;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_chans  <= n_chans;
            r_offset <= n_offset;
            r_settle <= cfg_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_geom <= n_geom;
    end

    assign o_geom        = r_geom;
    assign o_ctl.restart = cfg_hit;
    assign o_ctl.busy    = r_settle || i_cfg.valid;

endmodule

FILE: rtl/bbb_window.sv
// Input brightening, two-line buffer, channel-spaced delay taps and output position tracking.
module bbb_window import bbb_pkg::*; #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 4096,
    parameter int MAX_CHANNELS = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bbb_in_if.sink   i_in,
    input  t_geom    i_geom,
    input  t_cfg_ctl i_ctl,
    input  logic     i_take,
    output logic     o_win_valid,
    output t_win     o_win
);

    localparam int EFF_W = (MAX_WIDTH < WIDTH_FIELD_MAX) ? MAX_WIDTH : WIDTH_FIELD_MAX;
    localparam int EFF_H = (MAX_HEIGHT < HEIGHT_FIELD_MAX) ? MAX_HEIGHT : HEIGHT_FIELD_MAX;
    localparam int DEPTH = EFF_W * MAX_CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W = $clog2(EFF_W);
    localparam int ROW_W = $clog2(EFF_H);

    logic [LAG_W-1:0]      r_pre,  n_pre;
    logic [ROWLEN_W-1:0]   r_ptr,  n_ptr;
    logic [ROWLEN_W-1:0]   r_wptr;
    logic [COL_W-1:0]      r_col,  n_col;
    logic [ROW_W-1:0]      r_row,  n_row;
    logic [CHAN_CNT_W-1:0] r_chan, n_chan;
    logic                  r_v0,   n_v0;
    logic [SAMPLE_W-1:0]   r_b0;
    logic [LINE_W-1:0]     r_byp;
    logic                  r_interior;
    logic                  r_last;
    logic [SAMPLE_W-1:0]   r_dl [6][MAX_CHANNELS];

    logic                fire;
    logic                has_res;
    logic [SAMPLE_W-1:0] br;
    logic [LINE_W-1:0]   ram_q;
    logic [LINE_W-1:0]   q_eff;
    logic [LINE_W-1:0]   wdata;
    logic [SAMPLE_W-1:0] mid0;
    logic [SAMPLE_W-1:0] top0;
    logic [SAMPLE_W-1:0] dl_in [6];
    logic                chan_last;
    logic                col_last;
    logic                row_last;
    logic                frame_end;
    logic                interior;

    assign i_in.ready = (!r_v0 || i_take) && !i_ctl.busy;
    assign fire       = i_in.valid && i_in.ready;
    assign has_res    = (r_pre == i_geom.lag);
    assign br         = brighten(i_in.sample, i_geom.offset);

    assign q_eff = i_geom.row_one ? r_byp : ram_q;
    assign mid0  = q_eff[LINE_W-1:SAMPLE_W];
    assign top0  = q_eff[SAMPLE_W-1:0];
    assign wdata = {r_b0, mid0};

    bbb_ram #(
        .WIDTH (LINE_W),
        .DEPTH (DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (fire),
        .i_waddr (r_wptr[AW-1:0]),
        .i_wdata (wdata),
        .i_re    (fire),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (ram_q)
    );

    assign chan_last = (CHANS_W'(r_chan) == i_geom.chans - CHANS_W'(1));
    assign col_last  = (WIDTH_W'(r_col) == i_geom.width - WIDTH_W'(1));
    assign row_last  = (HEIGHT_W'(r_row) == i_geom.height - HEIGHT_W'(1));
    assign frame_end = chan_last && col_last && row_last;
    assign interior  = (r_row != '0) && !row_last && (r_col != '0) && !col_last;

    always_comb begin
        n_pre  = r_pre;
        n_ptr  = r_ptr;
        n_col  = r_col;
        n_row  = r_row;
        n_chan = r_chan;
        n_v0   = (fire && has_res) || (r_v0 && !i_take);
        if (i_ctl.restart) begin
            n_pre  = '0;
            n_ptr  = '0;
            n_col  = '0;
            n_row  = '0;
            n_chan = '0;
        end else if (fire) begin
            n_ptr = (r_ptr == i_geom.row_len - ROWLEN_W'(1)) ? '0 : r_ptr + ROWLEN_W'(1);
            if (!has_res) begin
                n_pre = r_pre + LAG_W'(1);
            end else if (frame_end) begin
                n_pre  = '0;
                n_ptr  = '0;
                n_col  = '0;
                n_row  = '0;
                n_chan = '0;
            end else if (!chan_last) begin
                n_chan = r_chan + CHAN_CNT_W'(1);
            end else begin
                n_chan = '0;
                if (!col_last) begin
                    n_col = r_col + COL_W'(1);
                end else begin
                    n_col = '0;
                    n_row = r_row + ROW_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre  <= '0;
            r_ptr  <= '0;
            r_col  <= '0;
            r_row  <= '0;
            r_chan <= '0;
            r_v0   <= 1'b0;
        end else begin
            r_pre  <= n_pre;
            r_ptr  <= n_ptr;
            r_col  <= n_col;
            r_row  <= n_row;
            r_chan <= n_chan;
            r_v0   <= n_v0;
        end
    end

    // delay lines of exactly chans transfers; the newest entry lands at index chans-1
    assign dl_in[0] = r_b0;
    assign dl_in[1] = r_dl[0][0];
    assign dl_in[2] = mid0;
    assign dl_in[3] = r_dl[2][0];
    assign dl_in[4] = top0;
    assign dl_in[5] = r_dl[4][0];

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_b0   <= br;
            r_byp  <= wdata;
            r_wptr <= r_ptr;
            for (int l = 0; l < 6; l++) begin
                for (int k = 0; k < MAX_CHANNELS; k++) begin
                    if (k == MAX_CHANNELS - 1 || k == int'(i_geom.chans) - 1) begin
                        r_dl[l][k] <= dl_in[l];
                    end else begin
                        r_dl[l][k] <= r_dl[l][(k + 1 < MAX_CHANNELS) ? k + 1 : k];
                    end
                end
            end
        end
        if (fire && has_res) begin
            r_interior <= interior;
            r_last     <= frame_end;
        end
    end

    assign o_win_valid  = r_v0;
    assign o_win.tap[0] = r_b0;
    assign o_win.tap[1] = r_dl[0][0];
    assign o_win.tap[2] = r_dl[1][0];
    assign o_win.tap[3] = mid0;
    assign o_win.tap[4] = r_dl[2][0];
    assign o_win.tap[5] = r_dl[3][0];
    assign o_win.tap[6] = top0;
    assign o_win.tap[7] = r_dl[4][0];
    assign o_win.tap[8] = r_dl[5][0];
    assign o_win.bright   = r_dl[2][0];
    assign o_win.interior = r_interior;
    assign o_win.last     = r_last;

endmodule

FILE: rtl/bbb_mean.sv
// Three-stage sum, divide-by-nine and output register pipeline.
module bbb_mean import bbb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_win_valid,
    input  t_win      i_win,
    output logic      o_take,
    bbb_out_if.source o_out
);

    logic                r_v1, r_v2, r_v3;
    logic [9:0]          r_rsum [3];
    logic [SAMPLE_W-1:0] r_br1, r_br2, r_bright;
    logic                r_int1, r_int2;
    logic                r_last1, r_last2, r_last3;
    logic [11:0]         r_sum;
    logic [SAMPLE_W-1:0] r_filt;

    logic adv1, adv2, adv3;

    assign adv3   = !r_v3 || o_out.ready;
    assign adv2   = !r_v2 || adv3;
    assign adv1   = !r_v1 || adv2;
    assign o_take = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_win_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_win_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_rsum[r] <= {2'b00, i_win.tap[3*r]} + {2'b00, i_win.tap[3*r+1]}
                           + {2'b00, i_win.tap[3*r+2]};
            end
            r_br1   <= i_win.bright;
            r_int1  <= i_win.interior;
            r_last1 <= i_win.last;
        end
        if (adv2 && r_v1) begin
            r_sum   <= {2'b00, r_rsum[0]} + {2'b00, r_rsum[1]} + {2'b00, r_rsum[2]};
            r_br2   <= r_br1;
            r_int2  <= r_int1;
            r_last2 <= r_last1;
        end
        if (adv3 && r_v2) begin
            r_bright <= r_br2;
            r_filt   <= r_int2 ? mean9(r_sum) : r_br2;
            r_last3  <= r_last2;
        end
    end

    assign o_out.valid          = r_v3;
    assign o_out.bright_value   = r_bright;
    assign o_out.filtered_value = r_filt;
    assign o_out.frame_last     = r_last3;

endmodule

FILE: rtl/brightness_box_blur_3x3_top.sv
// Top level of the brightness adjust and 3x3 same-channel box mean stream block.
// Throughput: one sample transfer per clock without output stalls or register writes; results
// follow (width+1)*channels transfers behind. A window is registered at the transfer that
// completes it, then goes through row sums, total sum and the divide-by-nine output register.
// Reset (synchronous, active low) restores default registers and clears all counters; the line
// RAM is not cleared. Input is held off in the cycle after reset and after each register write.
module brightness_box_blur_3x3_top import bbb_pkg::*; #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 4096,
    parameter int MAX_CHANNELS = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bbb_in_if.sink    i_in,
    bbb_out_if.source o_out,
    bbb_cfg_if.sink   i_cfg
);

    t_geom    geom;
    t_cfg_ctl ctl;
    t_win     win;
    logic     win_valid;
    logic     take;

    bbb_cfg #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_geom  (geom),
        .o_ctl   (ctl)
    );

    bbb_window #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_geom      (geom),
        .i_ctl       (ctl),
        .i_take      (take),
        .o_win_valid (win_valid),
        .o_win       (win)
    );

    bbb_mean u_mean (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win_valid (win_valid),
        .i_win       (win),
        .o_take      (take),
        .o_out       (o_out)
    );

    a_cfg_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.valid && i_cfg.ready && (i_cfg.index == REG_WIDTH || i_cfg.index == REG_HEIGHT
            || i_cfg.index == REG_CHANS || i_cfg.index == REG_OFFSET) |=> !i_in.ready)
        else $error("input ready one clock after a register write");

    a_last_on_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win_valid && win.last |-> !win.interior)
        else $error("final pixel of frame marked interior");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid && !win_valid)
        else $error("pipeline holds data after reset");

endmodule

FILE: sim/tb_brightness_box_blur_3x3_top.sv
// Self-checking bench: brightness adjust and 3x3 mean stream checked against a scoreboard.
`timescale 1ns / 100ps

module tb_brightness_box_blur_3x3_top;
    import bbb_pkg::*;

    localparam int FRAME_W_MAX   = 1024;
    localparam int FRAME_H_MAX   = 4096;
    localparam int CHAN_MAX      = 4;
    localparam int RING_DEPTH    = 16384;
    localparam int RANDOM_ITEMS  = 170;
    localparam int SETTLE_CYCLES = 10;
    localparam int QUIET_LIMIT   = 2000;
    localparam int NO_PAUSE      = -1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] bright;
        logic [SAMPLE_W-1:0] filtered;
        logic                last;
    } t_pixel;

    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_HIGH,
        FILL_LOW,
        FILL_MIXED
    } t_fill;

    class blur_scoreboard;
        logic [WIDTH_W-1:0]         width_reg;
        logic [HEIGHT_W-1:0]        height_reg;
        logic [CHANS_W-1:0]         chans_reg;
        logic signed [OFFSET_W-1:0] offset_reg;
        int unsigned                pos, col, row, chan;
        logic [SAMPLE_W-1:0]        bright_ring [RING_DEPTH];
        t_pixel                     expected_pixels [$];
        int unsigned                error_count;

        function new();
            width_reg   = RST_WIDTH;
            height_reg  = RST_HEIGHT;
            chans_reg   = RST_CHANS;
            offset_reg  = RST_OFFSET;
            error_count = 0;
            restart();
        endfunction

        function void restart();
            pos  = 0;
            col  = 0;
            row  = 0;
            chan = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_WIDTH:  width_reg  = d[WIDTH_W-1:0];
                REG_HEIGHT: height_reg = d[HEIGHT_W-1:0];
                REG_CHANS:  chans_reg  = d[CHANS_W-1:0];
                REG_OFFSET: offset_reg = d[OFFSET_W-1:0];
                default:    return;
            endcase
            restart();
        endfunction

        function void frame_shape(output int unsigned w, output int unsigned h,
                                  output int unsigned c, output int unsigned total,
                                  output int unsigned lag);
            w = (width_reg == 0) ? 1 : (width_reg > FRAME_W_MAX) ? FRAME_W_MAX : width_reg;
            h = (height_reg == 0) ? 1 : (height_reg > FRAME_H_MAX) ? FRAME_H_MAX : height_reg;
            c = (chans_reg == 0) ? 1 : (chans_reg > CHAN_MAX) ? CHAN_MAX : chans_reg;
            total = w * h * c;
            lag   = (w + 1) * c;
        endfunction

        function logic [SAMPLE_W-1:0] adjust(input logic [SAMPLE_W-1:0] s);
            int v;
            v = int'(s) + int'(offset_reg);
            if (v > 255) return 8'd255;
            if (v < 0) return 8'd0;
            return v[SAMPLE_W-1:0];
        endfunction

        function void note_sample(input logic [SAMPLE_W-1:0] s);
            int unsigned w, h, c, total, lag, p, row_step, corner, sum, dy, dx;
            t_pixel      px;
            frame_shape(w, h, c, total, lag);
            if (pos < total) bright_ring[pos % RING_DEPTH] = adjust(s);
            if (pos < lag) begin
                pos++;
                return;
            end
            p = pos - lag;
            px.bright   = bright_ring[p % RING_DEPTH];
            px.filtered = px.bright;
            if (row >= 1 && row + 1 < h && col >= 1 && col + 1 < w) begin
                row_step = w * c;
                corner   = p - row_step - c;
                sum      = 0;
                for (dy = 0; dy < 3; dy++) begin
                    for (dx = 0; dx < 3; dx++) begin
                        sum += bright_ring[(corner + dy * row_step + dx * c) % RING_DEPTH];
                    end
                end
                px.filtered = SAMPLE_W'(sum / 9);
            end
            px.last = (p + 1 >= total);
            expected_pixels.push_back(px);
            if (px.last) begin
                restart();
            end else begin
                pos++;
                chan++;
                if (chan >= c) begin
                    chan = 0;
                    col++;
                    if (col >= w) begin
                        col = 0;
                        row++;
                    end
                end
            end
        endfunction

        function void note_error(input string msg);
            error_count++;
            if (error_count <= 10) $display("%s", msg);
        endfunction

        function void check_pixel(input logic [SAMPLE_W-1:0] b, input logic [SAMPLE_W-1:0] f,
                                  input logic l);
            t_pixel want;
            if (expected_pixels.size() == 0) begin
                note_error($sformatf("unexpected result: bright %0d filtered %0d last %0b",
                                     b, f, l));
                return;
            end
            want = expected_pixels.pop_front();
            if (want.bright !== b || want.filtered !== f || want.last !== l) begin
                note_error($sformatf(
                    "mismatch: bright exp %0d got %0d, filtered exp %0d got %0d, last exp %0b got %0b",
                    want.bright, b, want.filtered, f, want.last, l));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bbb_in_if  in_ch ();
    bbb_out_if out_ch ();
    bbb_cfg_if cfg_ch ();

    blur_scoreboard sb;
    int unsigned    quiet_cycles = 0;
    int unsigned    samples_sent = 0;
    int unsigned    tx_mode_left = 0;
    bit             tx_calm      = 1'b0;

    brightness_box_blur_3x3_top #(
        .MAX_WIDTH    (FRAME_W_MAX),
        .MAX_HEIGHT   (FRAME_H_MAX),
        .MAX_CHANNELS (CHAN_MAX)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SAMPLE_W-1:0] next_sample(input t_fill fill);
        case (fill)
            FILL_HIGH:  return SAMPLE_MAX;
            FILL_LOW:   return '0;
            FILL_MIXED: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return SAMPLE_MAX;
                    default: return SAMPLE_W'($urandom);
                endcase
            end
            default:    return SAMPLE_W'($urandom);
        endcase
    endfunction

    // low bits carry the field, upper bits are junk the block must drop
    function automatic logic [CFG_DATA_W-1:0] cfg_word(input int field_w, input int value);
        logic [CFG_DATA_W-1:0] junk, field;
        junk  = CFG_DATA_W'($urandom);
        field = CFG_DATA_W'(value) & ((CFG_DATA_W'(1) << field_w) - 1'b1);
        return (junk << field_w) | field;
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int unsigned gap;
        if (tx_mode_left == 0) begin
            tx_calm      = ($urandom_range(0, 3) == 0);
            tx_mode_left = $urandom_range(30, 300);
        end
        tx_mode_left--;
        gap = (!tx_calm && $urandom_range(0, 99) < 25) ? idle_len() : 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= s;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_sample(s);
        samples_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.set_reg(idx, d);
    endtask

    task automatic load_geometry(input int w, input int h, input int c, input int off);
        write_reg(REG_WIDTH,  cfg_word(WIDTH_W, w));
        write_reg(REG_HEIGHT, cfg_word(HEIGHT_W, h));
        write_reg(REG_CHANS,  cfg_word(CHANS_W, c));
        write_reg(REG_OFFSET, cfg_word(OFFSET_W, off));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_pixels.size() != 0);
    endtask

    task automatic settle_idle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_frame(input t_fill fill, input int unsigned cut, input int pause_at);
        int unsigned w, h, c, total, lag, n, k;
        sb.frame_shape(w, h, c, total, lag);
        n = total + lag;
        if (cut != 0 && cut < n) n = cut;
        for (k = 0; k < n; k++) begin
            send_sample(next_sample(fill));
            if (int'(k) == pause_at || $urandom_range(0, 399) == 0) hold_until_drained();
        end
    endtask

    // output side backpressure
    initial begin
        int unsigned stall_left, mode_left;
        bit          calm;
        stall_left = 0;
        mode_left  = 0;
        calm       = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                calm      = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(40, 400);
            end
            mode_left--;
            if (stall_left != 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 25) stall_left = idle_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                sb.check_pixel(out_ch.bright_value, out_ch.filtered_value, out_ch.frame_last);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int unsigned w, h, c, total, lag, base, n_frames, f, cut, k;
        bit          wrote;
        t_fill       fill;
        sb = new();
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.sample <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_WIDTH;
        cfg_ch.data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry; cut short well before results flow
        run_frame(FILL_MIXED, 20, NO_PAUSE);
        settle_idle();
        // small frame on the reset offset
        write_reg(REG_WIDTH,  cfg_word(WIDTH_W, 3));
        write_reg(REG_HEIGHT, cfg_word(HEIGHT_W, 3));
        write_reg(REG_CHANS,  cfg_word(CHANS_W, 1));
        cfg_ch.valid <= 1'b0;
        run_frame(FILL_MIXED, 0, NO_PAUSE);
        settle_idle();
        load_geometry(3, 3, 1, 0);
        run_frame(FILL_HIGH, 0, NO_PAUSE);
        settle_idle();
        load_geometry(3, 3, 2, -256);
        run_frame(FILL_HIGH, 0, NO_PAUSE);
        settle_idle();
        load_geometry(4, 3, 7, 255);
        run_frame(FILL_LOW, 0, NO_PAUSE);
        settle_idle();
        load_geometry(5, 4, 3, -1);
        run_frame(FILL_MIXED, 0, 20);
        settle_idle();
        load_geometry(1, 1, 1, 37);
        run_frame(FILL_RANDOM, 0, NO_PAUSE);
        settle_idle();
        load_geometry(0, 0, 0, -100);
        run_frame(FILL_RANDOM, 0, NO_PAUSE);
        settle_idle();
        load_geometry(7, 5, 2, -30);
        run_frame(FILL_RANDOM, 30, NO_PAUSE);
        settle_idle();
        load_geometry(WIDTH_FIELD_MAX, 1, 1, 10);
        run_frame(FILL_MIXED, 20, NO_PAUSE);
        settle_idle();
        load_geometry(1, HEIGHT_FIELD_MAX, 1, -10);
        run_frame(FILL_MIXED, 20, NO_PAUSE);
        settle_idle();
        load_geometry(5, 3, 2, 20);
        // indexes past the register list leave the frame running
        for (k = int'(REG_OFFSET) + 1; k < (1 << CFG_IDX_W); k++) begin
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
        end
        cfg_ch.valid <= 1'b0;
        run_frame(FILL_RANDOM, 0, NO_PAUSE);
        run_frame(FILL_MIXED, 0, NO_PAUSE);

        base = samples_sent;
        while (samples_sent - base < RANDOM_ITEMS) begin
            settle_idle();
            wrote = 1'b0;
            if ($urandom_range(0, 1) == 1) begin
                write_reg(REG_WIDTH, cfg_word(WIDTH_W, $urandom_range(0, 9)));
                wrote = 1'b1;
            end
            if ($urandom_range(0, 1) == 1) begin
                write_reg(REG_HEIGHT, cfg_word(HEIGHT_W, $urandom_range(0, 6)));
                wrote = 1'b1;
            end
            if ($urandom_range(0, 1) == 1) begin
                write_reg(REG_CHANS, cfg_word(CHANS_W, $urandom_range(0, 7)));
                wrote = 1'b1;
            end
            if (!wrote || $urandom_range(0, 1) == 1) begin
                write_reg(REG_OFFSET, cfg_word(OFFSET_W, $urandom_range(0, 511)));
            end
            cfg_ch.valid <= 1'b0;
            n_frames = $urandom_range(1, 3);
            for (f = 0; f < n_frames; f++) begin
                sb.frame_shape(w, h, c, total, lag);
                cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total + lag - 1) : 0;
                fill = ($urandom_range(0, 3) == 0) ? FILL_MIXED : FILL_RANDOM;
                run_frame(fill, cut, NO_PAUSE);
                if (cut != 0) break;
            end
        end

        settle_idle();
        if (sb.error_count == 0 && sb.expected_pixels.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/bbb_pkg.sv
rtl/bbb_ifs.sv
rtl/bbb_ram.sv
rtl/bbb_cfg.sv
rtl/bbb_window.sv
rtl/bbb_mean.sv
rtl/brightness_box_blur_3x3_top.sv
sim/tb_brightness_box_blur_3x3_top.sv
